// ----- hw/rtl/chebyshev_series_evaluator_assert.svh -----
// Assertion macros for the Chebyshev series evaluator RTL.
// Every macro expects signals named clk and rst in the using scope.
`ifndef CHEBYSHEV_SERIES_EVALUATOR_ASSERT_SVH
`define CHEBYSHEV_SERIES_EVALUATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cse_pkg.sv -----
// Shared types, codes and saturation helper for the Chebyshev series evaluator.
// No dependencies.
`timescale 1ns / 1ps

package cse_pkg;

  localparam int ORDER_W = 5;
  localparam int DATA_W  = 32;

  // Item codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_ORDER  = 2'd0;
  localparam logic [1:0] REG_CENTER = 2'd1;
  localparam logic [1:0] REG_GAIN   = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              clip;
  } sat_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] y;
    logic              sat;
  } cse_result_t;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    if (v > 66'sd2147483647) begin
      r.val  = 32'h7FFF_FFFF;
      r.clip = 1'b1;
    end else if (v < -66'sd2147483648) begin
      r.val  = 32'h8000_0000;
      r.clip = 1'b1;
    end else begin
      r.val  = v[31:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/cse_coef_mem.sv -----
// Coefficient store: one write port and one read port with registered read data.
// Depends on cse_pkg.
`timescale 1ns / 1ps

module cse_coef_mem
  import cse_pkg::*;
#(
  parameter int MAX_ORDER = 16,
  localparam int AW = $clog2(MAX_ORDER + 1)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [MAX_ORDER+1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/cse_engine.sv -----
// Evaluation sequencer: input scaling and the Clenshaw recurrence around one
// shared multiplier. Depends on cse_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "chebyshev_series_evaluator_assert.svh"

module cse_engine
  import cse_pkg::*;
#(
  parameter int MAX_ORDER = 16,
  localparam int AW = $clog2(MAX_ORDER + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               eval_go,
  input  logic [DATA_W-1:0]  x_value,
  input  logic [ORDER_W-1:0] order_in_use,
  input  logic [DATA_W-1:0]  x_center,
  input  logic [DATA_W-1:0]  x_gain,
  output logic               busy,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  logic [DATA_W-1:0]  rd_data,
  output cse_result_t        res
);

  localparam int CW = (AW > ORDER_W) ? AW : ORDER_W;

  typedef enum logic [2:0] {
    S_IDLE, S_ZERO, S_DIFF, S_SCALE, S_XS, S_MUL, S_ACC
  } state_t;

  state_t state;

  logic [AW-1:0]        n_reg;
  logic [AW-1:0]        k;
  logic signed [31:0]   x_reg;
  logic signed [32:0]   diff;
  logic signed [64:0]   prod;
  logic signed [31:0]   xs;
  logic signed [31:0]   u1;
  logic signed [31:0]   u2;
  logic                 flag;

  logic [CW-1:0]        ord_ext;
  logic [AW-1:0]        n_clamped;
  logic signed [32:0]   mul_a;
  logic signed [31:0]   mul_b;
  logic signed [64:0]   prod_w;
  logic signed [65:0]   prod_ext;
  logic signed [65:0]   xs_round;
  logic signed [65:0]   r23;
  logic signed [65:0]   r24;
  logic signed [65:0]   c_ext;
  logic signed [65:0]   u2_ext;
  logic signed [65:0]   acc;
  sat_t                 xs_sat;
  sat_t                 acc_sat;

  assign ord_ext   = CW'(order_in_use);
  assign n_clamped = (ord_ext > CW'(MAX_ORDER)) ? AW'(MAX_ORDER) : AW'(ord_ext);

  // The multiplier scales the input first and then serves every recurrence step.
  always_comb begin
    if (state == S_SCALE) begin
      mul_a = diff;
      mul_b = $signed(x_gain);
    end else begin
      mul_a = {xs[31], xs};
      mul_b = u1;
    end
  end

  assign prod_w   = mul_a * mul_b;
  assign prod_ext = {prod[64], prod};
  assign xs_round = (prod_ext + 66'sd128) >>> 8;
  assign r23      = (prod_ext + 66'sd4194304) >>> 23;
  assign r24      = (prod_ext + 66'sd8388608) >>> 24;
  assign c_ext    = {{34{rd_data[31]}}, rd_data};
  assign u2_ext   = {{34{u2[31]}}, u2};
  assign acc      = ((k == '0) ? r24 : r23) - u2_ext + c_ext;
  assign xs_sat   = sat32(xs_round);
  assign acc_sat  = sat32(acc);

  assign busy = (state != S_IDLE);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      S_IDLE: begin
        rd_en = eval_go;
      end
      S_DIFF: begin
        rd_en   = 1'b1;
        rd_addr = n_reg;
      end
      S_MUL: begin
        rd_en   = 1'b1;
        rd_addr = k;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res.valid <= 1'b0;
    end else begin
      res.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (eval_go) begin
            x_reg <= $signed(x_value);
            n_reg <= n_clamped;
            flag  <= 1'b0;
            state <= (n_clamped == '0) ? S_ZERO : S_DIFF;
          end
        end
        S_ZERO: begin
          res.valid <= 1'b1;
          res.y     <= rd_data;
          res.sat   <= 1'b0;
          state     <= S_IDLE;
        end
        S_DIFF: begin
          diff  <= {x_reg[31], x_reg} - {x_center[31], x_center};
          state <= S_SCALE;
        end
        S_SCALE: begin
          prod  <= prod_w;
          u1    <= $signed(rd_data);
          u2    <= '0;
          k     <= n_reg - 1'b1;
          state <= S_XS;
        end
        S_XS: begin
          xs    <= $signed(xs_sat.val);
          flag  <= flag | xs_sat.clip;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= prod_w;
          state <= S_ACC;
        end
        S_ACC: begin
          if (k == '0) begin
            res.valid <= 1'b1;
            res.y     <= acc_sat.val;
            res.sat   <= flag | acc_sat.clip;
            state     <= S_IDLE;
          end else begin
            flag  <= flag | acc_sat.clip;
            u2    <= u1;
            u1    <= $signed(acc_sat.val);
            k     <= k - 1'b1;
            state <= S_MUL;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CSE_ASSERT_NEXT(a_done_single, res.valid, !res.valid, "result strobe held for two cycles")
  `CSE_ASSERT_NEXT(a_loop_back, state == S_ACC && k != '0, state == S_MUL, "recurrence left early")
  `CSE_ASSERT_SAME(a_done_source, res.valid, $past(state) == S_ACC || $past(state) == S_ZERO, "result without final step")
  `CSE_ASSERT_SAME(a_rd_range, rd_en, rd_addr <= AW'(MAX_ORDER), "coefficient read beyond table")

endmodule

// ----- hw/rtl/chebyshev_series_evaluator.sv -----
// Chebyshev series evaluator: a write word gives no result and leaves the block idle.
// An evaluate word of effective order N>=1 passes through the difference, scale and
// input steps, then a multiply then accumulate step per order through the one shared
// multiplier; order 0 returns the constant term. No new word is taken while busy,
// and busy falls as the result appears. Synchronous reset clears control and the
// registers (gain to 1.0); the coefficient memory is left as it is.
`timescale 1ns / 1ps

module chebyshev_series_evaluator
  import cse_pkg::*;
#(
  parameter int MAX_ORDER = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic [4:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] x_value,
  output logic               done,
  output logic signed [31:0] y_value,
  output logic               saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(MAX_ORDER + 1);
  localparam int CW = (AW > ORDER_W) ? AW : ORDER_W;

  logic [ORDER_W-1:0] order_in_use;
  logic [DATA_W-1:0]  x_center;
  logic [DATA_W-1:0]  x_gain;

  logic               accept;
  logic               eval_go;
  logic               wr_en;
  logic               cfg_wr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [DATA_W-1:0]  rd_data;
  cse_result_t        res;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_in_use <= '0;
      x_center     <= '0;
      x_gain       <= 32'd65536;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ORDER:  order_in_use <= pwdata[ORDER_W-1:0];
        REG_CENTER: x_center     <= pwdata;
        REG_GAIN:   x_gain       <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ORDER:  prdata = {{(DATA_W-ORDER_W){1'b0}}, order_in_use};
      REG_CENTER: prdata = x_center;
      REG_GAIN:   prdata = x_gain;
      default:    prdata = '0;
    endcase
  end

  assign accept  = start & ~busy;
  assign eval_go = accept & (opcode == OP_EVAL);
  // Writes to slots past the table are dropped.
  assign wr_en   = accept & (opcode == OP_WRITE) & (CW'(coef_index) <= CW'(MAX_ORDER));

  cse_coef_mem #(
    .MAX_ORDER(MAX_ORDER)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(coef_index)),
    .wr_data (coef_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cse_engine #(
    .MAX_ORDER(MAX_ORDER)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .eval_go      (eval_go),
    .x_value      (x_value),
    .order_in_use (order_in_use),
    .x_center     (x_center),
    .x_gain       (x_gain),
    .busy         (busy),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .res          (res)
  );

  assign done      = res.valid;
  assign y_value   = $signed(res.y);
  assign saturated = res.sat;

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for chebyshev_series_evaluator: random and directed words
// checked against a Clenshaw recurrence predictor held in a small scoreboard class.
// Depends on cse_pkg and the chebyshev_series_evaluator RTL.
`timescale 1ns / 1ps

module tb;
  import cse_pkg::*;

  localparam int          MAX_ORDER     = 16;
  localparam int          ITEM_TARGET   = 1700;
  localparam int          SETTLE_CYCLES = 2 * MAX_ORDER + 8;
  localparam int          RUN_LIMIT_NS  = 10_000_000;
  localparam logic [1:0]  REG_SPARE     = 2'd3;

  typedef struct packed {
    logic signed [31:0] y;
    logic               sat;
  } series_out_t;

  class series_scoreboard;
    logic signed [31:0] coef_tbl [MAX_ORDER+1];
    logic [4:0]         order_reg;
    logic signed [31:0] center_reg;
    logic signed [31:0] gain_reg;
    logic               clipped;
    series_out_t        pending_q[$];
    int                 errors;

    function new();
      order_reg  = '0;
      center_reg = '0;
      gain_reg   = 32'sh0001_0000;
      errors     = 0;
      foreach (coef_tbl[i]) coef_tbl[i] = '0;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_reg(input logic [1:0] idx, input logic [31:0] data);
      case (idx)
        REG_ORDER:  order_reg  = data[4:0];
        REG_CENTER: center_reg = data;
        REG_GAIN:   gain_reg   = data;
        default: ;
      endcase
    endfunction

    function logic signed [31:0] clamp32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
        clipped = 1'b1;
        return 32'sh7FFF_FFFF;
      end
      if (v < -66'sd2147483648) begin
        clipped = 1'b1;
        return 32'sh8000_0000;
      end
      return v[31:0];
    endfunction

    // Round half up: add half an LSB of the result, then floor.
    function logic signed [65:0] round_sh(input logic signed [65:0] v, input int s);
      return (v + (66'sd1 <<< (s - 1))) >>> s;
    endfunction

    function series_out_t series_value(input logic signed [31:0] x);
      series_out_t        r;
      int                 n;
      int                 k;
      logic signed [65:0] a, b, t;
      logic signed [31:0] xs, uk, uk1, uk2;
      clipped = 1'b0;
      n = (order_reg > 5'(MAX_ORDER)) ? MAX_ORDER : int'(order_reg);
      if (n == 0) begin
        r.y   = coef_tbl[0];
        r.sat = 1'b0;
        return r;
      end
      a  = x;
      b  = center_reg;
      t  = a - b;
      b  = gain_reg;
      xs = clamp32(round_sh(t * b, 8));
      if (n == 1) begin
        a = coef_tbl[1];
        b = xs;
        t = round_sh(a * b, 24);
        a = coef_tbl[0];
        r.y = clamp32(a + t);
      end else begin
        uk1 = coef_tbl[n];
        uk2 = '0;
        uk  = '0;
        // The shift by 23 rather than 24 supplies the factor of two in the recurrence.
        for (k = n - 1; k >= 1; k--) begin
          a  = xs;
          b  = uk1;
          t  = round_sh(a * b, 23);
          a  = uk2;
          b  = coef_tbl[k];
          uk = clamp32(t - a + b);
          if (k > 1) begin
            uk2 = uk1;
            uk1 = uk;
          end
        end
        a = xs;
        b = uk;
        t = round_sh(a * b, 24);
        a = uk1;
        b = coef_tbl[0];
        r.y = clamp32(t - a + b);
      end
      r.sat = clipped;
      return r;
    endfunction

    function void note_word(input logic op, input logic [4:0] idx,
                            input logic signed [31:0] cval, input logic signed [31:0] xval);
      if (op == OP_WRITE) begin
        if (idx <= 5'(MAX_ORDER)) coef_tbl[idx] = cval;
      end else begin
        pending_q = {pending_q, series_value(xval)};
      end
    endfunction

    task check_result(input logic signed [31:0] y, input logic s);
      series_out_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("result y=%h sat=%b with nothing outstanding", y, s));
      end else begin
        e = pending_q.pop_front();
        if (y !== e.y) report($sformatf("y_value %h, predicted %h", y, e.y));
        if (s !== e.sat) report($sformatf("saturated %b, predicted %b", s, e.sat));
      end
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               opcode;
  logic [4:0]         coef_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] x_value;
  logic               done;
  logic signed [31:0] y_value;
  logic               saturated;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  series_scoreboard sb;
  int               random_items;

  chebyshev_series_evaluator #(.MAX_ORDER(MAX_ORDER)) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .x_value    (x_value),
    .done       (done),
    .y_value    (y_value),
    .saturated  (saturated),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Results are checked before the word accepted at the same edge is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(y_value, saturated);
      if (start && !busy) sb.note_word(opcode, coef_index, coef_value, x_value);
    end
  end

  task automatic send_word(input logic op, input logic [4:0] idx,
                           input logic [31:0] cval, input logic [31:0] xval);
    @(negedge clk);
    start      = 1'b1;
    opcode     = op;
    coef_index = idx;
    coef_value = cval;
    x_value    = xval;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk);
    start      = 1'b0;
    opcode     = $urandom;
    coef_index = $urandom;
    coef_value = $urandom;
    x_value    = $urandom;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic quiesce();
    hold_off(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Mostly small coefficients so that the recurrence stays in range.
  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: case ($urandom_range(0, 2))
           0:       return 32'h7FFF_FFFF;
           1:       return 32'h8000_0000;
           default: return 32'h0;
         endcase
      default: return 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
    endcase
  endfunction

  // Mostly points that map into the unit domain under the current centre and gain.
  function automatic logic [31:0] pick_x();
    longint      g;
    longint      span;
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1: return r;
      2:    return r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: begin
        g = longint'(sb.gain_reg);
        if (g < 0) g = -g;
        span = (g == 0) ? 64'sd1048576 : 64'sd4294967296 / g;
        if (span > 64'sd2147483647) span = 64'sd2147483647;
        return 32'(longint'(sb.center_reg) + longint'($urandom_range(0, 32'(2 * span)))
                   - span);
      end
    endcase
  endfunction

  task automatic random_setup();
    logic [31:0] d;
    d = $urandom;
    case ($urandom_range(0, 5))
      0: d[4:0] = 5'($urandom_range(0, 31));
      1: case ($urandom_range(0, 4))
           0:       d[4:0] = 5'd0;
           1:       d[4:0] = 5'd1;
           2:       d[4:0] = 5'd16;
           3:       d[4:0] = 5'd17;
           default: d[4:0] = 5'd31;
         endcase
      default: d[4:0] = 5'($urandom_range(2, MAX_ORDER));
    endcase
    reg_write(REG_ORDER, d);
    case ($urandom_range(0, 5))
      0: d = 32'h0;
      1: d = $urandom;
      2: d = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: d = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endcase
    reg_write(REG_CENTER, d);
    case ($urandom_range(0, 7))
      0: d = 32'h0001_0000;
      1: d = $urandom;
      2: case ($urandom_range(0, 2))
           0:       d = 32'h7FFF_FFFF;
           1:       d = 32'h8000_0000;
           default: d = 32'h0;
         endcase
      default: begin
        d = 32'($urandom_range(32'h0000_1000, 32'h0004_0000));
        if ($urandom_range(0, 1)) d = -d;
      end
    endcase
    reg_write(REG_GAIN, d);
  endtask

  initial begin : stimulus
    int          k;
    int          phase_len;
    int          write_pct;
    bit          idle_on;
    logic [4:0]  idx;
    sb           = new();
    random_items = 0;
    rst        = 1'b1;
    start      = 1'b0;
    opcode     = OP_WRITE;
    coef_index = '0;
    coef_value = '0;
    x_value    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Order zero returns the constant term, so a clamped xs must not raise the flag.
    reg_write(REG_SPARE, $urandom);
    reg_write(REG_CENTER, 32'h8000_0000);
    reg_write(REG_GAIN, 32'h7FFF_FFFF);
    send_word(OP_WRITE, 5'd0, 32'h7FFF_FFFF, $urandom);
    send_word(OP_EVAL, $urandom, $urandom, 32'h7FFF_FFFF);
    send_word(OP_WRITE, 5'd0, 32'h8000_0000, $urandom);
    send_word(OP_EVAL, $urandom, $urandom, 32'h8000_0000);
    send_word(OP_WRITE, 5'd31, $urandom, $urandom);
    send_word(OP_WRITE, 5'd17, $urandom, $urandom);
    send_word(OP_EVAL, $urandom, $urandom, 32'h0);
    quiesce();

    // First order, in range and then with xs clamped.
    reg_write(REG_ORDER, 32'd1);
    reg_write(REG_CENTER, 32'h0);
    reg_write(REG_GAIN, 32'h0001_0000);
    send_word(OP_WRITE, 5'd1, 32'h0100_0000, $urandom);
    send_word(OP_WRITE, 5'd0, 32'h0, $urandom);
    send_word(OP_EVAL, $urandom, $urandom, 32'h0000_8000);
    send_word(OP_EVAL, $urandom, $urandom, 32'h7FFF_FFFF);
    quiesce();

    // An order above the table is taken as the full table.
    reg_write(REG_ORDER, 32'd31);
    for (k = 2; k <= MAX_ORDER; k++)
      send_word(OP_WRITE, 5'(k), (k == MAX_ORDER) ? 32'h7FFF_FFFF : rand_coef(), $urandom);
    send_word(OP_EVAL, $urandom, $urandom, 32'h0001_0000);
    send_word(OP_EVAL, $urandom, $urandom, 32'hFFFF_0000);

    while (random_items < ITEM_TARGET) begin
      quiesce();
      random_setup();
      phase_len = $urandom_range(30, 120);
      write_pct = $urandom_range(5, 50);
      idle_on   = ($urandom_range(0, 2) != 0);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < write_pct) begin
          idx = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(MAX_ORDER + 1, 31))
                                            : 5'($urandom_range(0, MAX_ORDER));
          send_word(OP_WRITE, idx, rand_coef(), $urandom);
          if (idx <= 5'(MAX_ORDER)) random_items++;
        end else begin
          send_word(OP_EVAL, $urandom, $urandom, pick_x());
          random_items++;
        end
        if (idle_on && random_items < ITEM_TARGET - 200 && $urandom_range(0, 4) == 0)
          hold_off($urandom_range(1, 15));
        if ($urandom_range(0, 99) == 0) quiesce();
      end
    end

    quiesce();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

endmodule

// ----- chebyshev_series_evaluator.f -----
+incdir+hw/rtl
hw/rtl/cse_pkg.sv
hw/rtl/cse_coef_mem.sv
hw/rtl/cse_engine.sv
hw/rtl/chebyshev_series_evaluator.sv
dv/tb.sv
